// ===== design/pipe_list_command_parser_top_macros.svh =====
// Assertion macros used by the parser top module.
`ifndef PIPE_LIST_COMMAND_PARSER_TOP_MACROS_SVH
`define PIPE_LIST_COMMAND_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define PLCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define PLCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/plcp_pkg.sv =====
// Types, character codes and helper functions for the pipe-list command parser.
package plcp_pkg;

    // One input transaction: a packet byte and its end-of-packet flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic        accepted;
        logic [15:0] clear_mask;
    } res_item_t;

    // Parsing phase of the current section.
    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_LIST = 2'd1,
        PH_BAD  = 2'd2
    } phase_t;

    // Per-segment number conversion flags.
    typedef struct packed {
        logic nonempty;
        logic started;
        logic neg;
        logic stopped;
    } seg_flags_t;

    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Magic text that closes every valid packet, first character at index 0.
    localparam int MAGIC_LEN = 8;
    localparam logic [7:0] MAGIC_TEXT [MAGIC_LEN] = '{
        8'h61, 8'h21, 8'h63, 8'h2B, 8'h65, 8'h39, 8'h30, 8'h40
    };

    // Whitespace as the C library sees it: space, tab, newline, VT, FF, CR.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

endpackage

// ===== design/pipe_list_command_parser_top.sv =====
// Pipe-list command parser: suffix delay line, segment parser and result buffer.
// A result is registered from the last_byte transaction, into the skid stage if the output stalls.
// Throughput: one byte per cycle unless item_stall is high; the parser update is one register stage.
// The output register plus a skid stage let bytes flow while a result waits to be taken.
// Reset (rst_n low, asynchronous) empties the result buffer and returns the parser
// to its packet-start state; the suffix delay line needs no reset.
`include "pipe_list_command_parser_top_macros.svh"

module pipe_list_command_parser_top #(
    parameter int SLOT_COUNT    = 16,
    parameter int SUFFIX_LENGTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  plcp_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output plcp_pkg::res_item_t result
);
    import plcp_pkg::*;

    localparam int CW = $clog2(SUFFIX_LENGTH + 2);
    localparam int VW = $clog2(SLOT_COUNT + 1);
    localparam int PW = VW + 4;

    logic [7:0]        tail_reg [SUFFIX_LENGTH];
    logic [7:0]        tail_next [SUFFIX_LENGTH];
    logic [CW-1:0]     count_reg, count_next;
    phase_t            phase_reg, phase_next, phase_p;
    logic [VW-1:0]     value_reg, value_next, value_p;
    seg_flags_t        flags_reg, flags_next, flags_p;
    logic [SLOT_COUNT-1:0] pending_reg, pending_next, pending_p;

    logic              accept;
    logic              finish;
    logic [7:0]        c;
    logic [PW-1:0]     prod;
    logic              neg_seg;
    logic              suffix_ok;
    logic [15:0]       mask16;
    res_item_t         res_new;

    res_item_t         out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;

    assign accept = item_valid && !item_stall;
    assign finish = accept && item.last_byte;
    assign c      = tail_reg[0];

    // Parse the byte leaving the delay line, once the line is full.
    always_comb
    begin
        phase_p   = phase_reg;
        value_p   = value_reg;
        flags_p   = flags_reg;
        pending_p = pending_reg;
        neg_seg   = flags_reg.neg && (value_reg != '0);
        prod      = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1) + PW'(c[3:0]);
        if (count_reg >= CW'(SUFFIX_LENGTH))
        begin
            if (c == CH_COLON)
            begin
                phase_p   = PH_SKIP;
                value_p   = '0;
                flags_p   = '0;
                pending_p = '0;
            end
            else if (phase_reg == PH_SKIP)
            begin
                if (!is_space(c))
                begin
                    phase_p = (c == CH_PIPE) ? PH_LIST : PH_BAD;
                    value_p = '0;
                    flags_p = '0;
                end
            end
            else if (phase_reg == PH_LIST)
            begin
                if (c == CH_PIPE)
                begin
                    // Close the segment: a non-negative in-range value marks its slot.
                    if (flags_reg.nonempty && !neg_seg)
                    begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                        begin
                            if (value_reg == VW'(i))
                            begin
                                pending_p[i] = 1'b1;
                            end
                        end
                    end
                    value_p = '0;
                    flags_p = '0;
                end
                else
                begin
                    flags_p.nonempty = 1'b1;
                    if (!flags_reg.stopped)
                    begin
                        if (is_digit(c))
                        begin
                            flags_p.started = 1'b1;
                            value_p = (prod > PW'(SLOT_COUNT)) ? VW'(SLOT_COUNT)
                                                               : prod[VW-1:0];
                        end
                        else if (!flags_reg.started)
                        begin
                            if (!is_space(c))
                            begin
                                flags_p.started = 1'b1;
                                if (c == CH_MINUS)
                                begin
                                    flags_p.neg = 1'b1;
                                end
                                else if (c != CH_PLUS)
                                begin
                                    flags_p.stopped = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            flags_p.stopped = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Shift the delay line and advance the saturating byte count.
    always_comb
    begin
        for (int i = 0; i < SUFFIX_LENGTH - 1; i++)
        begin
            tail_next[i] = tail_reg[i + 1];
        end
        tail_next[SUFFIX_LENGTH - 1] = item.data_byte;
        count_next = (count_reg <= CW'(SUFFIX_LENGTH)) ? count_reg + CW'(1) : count_reg;
    end

    // Compare the shifted delay line, including the incoming byte, against the tail of the magic text.
    always_comb
    begin
        suffix_ok = 1'b1;
        for (int i = 0; i < SUFFIX_LENGTH; i++)
        begin
            if (tail_next[i] != MAGIC_TEXT[MAGIC_LEN - SUFFIX_LENGTH + i])
            begin
                suffix_ok = 1'b0;
            end
        end
    end

    // Slots above bit 15 are dropped; missing slots read as zero.
    for (genvar g = 0; g < 16; g++)
    begin : g_mask
        if (g < SLOT_COUNT)
        begin : g_slot
            assign mask16[g] = pending_p[g];
        end
        else
        begin : g_none
            assign mask16[g] = 1'b0;
        end
    end

    // Build the result and choose the next packet state.
    always_comb
    begin
        res_new.accepted   = (count_next == CW'(SUFFIX_LENGTH + 1)) &&
                             (phase_p == PH_LIST) && suffix_ok;
        res_new.clear_mask = res_new.accepted ? mask16 : 16'h0000;
    end

    always_comb
    begin
        if (finish)
        begin
            phase_next   = PH_SKIP;
            value_next   = '0;
            flags_next   = '0;
            pending_next = '0;
        end
        else
        begin
            phase_next   = phase_p;
            value_next   = value_p;
            flags_next   = flags_p;
            pending_next = pending_p;
        end
    end

    // Packet state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            phase_reg   <= PH_SKIP;
            value_reg   <= '0;
            flags_reg   <= '0;
            pending_reg <= '0;
        end
        else if (accept)
        begin
            count_reg   <= finish ? '0 : count_next;
            phase_reg   <= phase_next;
            value_reg   <= value_next;
            flags_reg   <= flags_next;
            pending_reg <= pending_next;
        end
    end

    // Delay line holding the candidate suffix.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tail_reg <= tail_next;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || !result_stall)
            begin
                out_valid_reg  <= skid_valid_reg || finish;
                skid_valid_reg <= 1'b0;
            end
            else if (finish)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !result_stall)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_new;
        end
        else if (finish)
        begin
            skid_reg <= res_new;
        end
    end

    assign item_stall   = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `PLCP_ASSERT_NOW(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid full while output empty")
    `PLCP_ASSERT_NOW(a_reject_zero_mask, out_valid_reg && !out_reg.accepted, out_reg.clear_mask == 16'h0000, "rejected result with nonzero mask")
    `PLCP_ASSERT_NEXT(a_packet_cleared, finish, (count_reg == '0) && (phase_reg == PH_SKIP), "packet state not cleared after last byte")
    `PLCP_ASSERT_NOW(a_mask_only_in_list, phase_reg != PH_LIST, pending_reg == '0, "pending mask set outside a pipe list")

endmodule
